@@ rtl/assert_macros.svh @@
// Assertion macros for the block size controller RTL.
// Both macros expect clk_i in the scope where they are used, and AABS_ASSERT also rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define AABS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every rising edge, reset included.
`define AABS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/aabs_pkg.sv @@
// Shared types, constants and tables of the adaptive audio block size controller.
// No dependencies; every other RTL file but assert_macros.svh uses it by scoped names.
package aabs_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 64;
  localparam int unsigned NUM_SIZES         = 3;

  localparam int unsigned CB_W     = 20;
  localparam int unsigned FRAMES_W = 13;
  localparam int unsigned SR_W     = 18;
  localparam int unsigned US_W     = 20;
  localparam int unsigned Q8_W     = 16;
  localparam int unsigned START_W  = 13;
  localparam int unsigned FSS_W    = 16;
  localparam int unsigned SIZE_W   = 8;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned REASON_W = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam int unsigned MUL_AW = 64;
  localparam int unsigned MUL_BW = 20;
  localparam int unsigned DIV_NW = 33;
  localparam int unsigned DIV_CW = 6;

  localparam logic [MUL_BW-1:0] US_PER_S = 20'd1000000;
  localparam logic [MUL_AW-1:0] HALF_US  = 64'd500000;

  // sample_rate / 5 by reciprocal multiplication, exact for 18-bit rates.
  localparam logic [18:0] COOL_RECIP = 19'd419431;
  localparam int unsigned COOL_SHIFT = 21;

  localparam logic [SR_W-1:0]  SR_RESET      = 18'd48000;
  localparam logic [FSS_W-1:0] COOL_RESET    = 16'd9600;
  localparam logic [US_W-1:0]  TARGET_RESET  = 20'd10000;
  localparam logic [US_W-1:0]  MAX_RESET     = 20'd20000;
  localparam logic [US_W-1:0]  MARGIN_RESET  = 20'd1000;
  localparam logic [Q8_W-1:0]  UPPER_RESET   = 16'd205;
  localparam logic [Q8_W-1:0]  LOWER_RESET   = 16'd128;
  localparam logic [Q8_W-1:0]  OVERLD_RESET  = 16'd256;
  localparam logic [START_W-1:0] START_RESET = 13'd96;
  localparam logic [IDX_W-1:0] IDX_RESET     = 2'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_RATE = 3'd0,
    REG_TARGET_LAT  = 3'd1,
    REG_MAX_LAT     = 3'd2,
    REG_MARGIN      = 3'd3,
    REG_UPPER_LOAD  = 3'd4,
    REG_LOWER_LOAD  = 3'd5,
    REG_FAST_OVERLD = 3'd6,
    REG_START_SIZE  = 3'd7
  } cfg_reg_e;

  typedef enum logic [REASON_W-1:0] {
    RSN_NONE    = 3'd0,
    RSN_FAST_UP = 3'd1,
    RSN_CRIT    = 3'd2,
    RSN_STEP_UP = 3'd3,
    RSN_STEP_DN = 3'd4
  } reason_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_BASE_SEL,
    ST_BASE_MUL,
    ST_BASE_DIV,
    ST_HIST_RD,
    ST_HIST_WR,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_P4,
    ST_DECIDE,
    ST_P5,
    ST_P6,
    ST_P7,
    ST_P8,
    ST_P9,
    ST_CHOOSE,
    ST_P10,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic              start;
    logic [MUL_AW-1:0] a;
    logic [MUL_BW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [MUL_AW-1:0] product;
  } mul_rsp_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] numer;
    logic [SR_W-1:0]   denom;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [US_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic            hit;
    logic [US_W-1:0] us;
  } base_hit_t;

  function automatic logic [SIZE_W-1:0] size_of(logic [IDX_W-1:0] idx);
    logic [SIZE_W-1:0] s;
    case (idx)
      2'd0:    s = 8'd64;
      2'd1:    s = 8'd96;
      2'd2:    s = 8'd128;
      default: s = 8'd64;
    endcase
    return s;
  endfunction

  // Block latency of a candidate, in units of 1/sample_rate microseconds.
  function automatic logic [MUL_AW-1:0] size_cost(logic [IDX_W-1:0] idx);
    logic [MUL_AW-1:0] c;
    case (idx)
      2'd0:    c = 64'd32000000;
      2'd1:    c = 64'd48000000;
      2'd2:    c = 64'd64000000;
      default: c = 64'd32000000;
    endcase
    return c;
  endfunction

  // Nearest candidate, ties to the smaller one; zero means the middle size.
  function automatic logic [IDX_W-1:0] pick_start(logic [START_W-1:0] p);
    logic [IDX_W-1:0] r;
    if (p == '0) begin
      r = 2'd1;
    end else if (p <= 13'd80) begin
      r = 2'd0;
    end else if (p <= 13'd112) begin
      r = 2'd1;
    end else begin
      r = 2'd2;
    end
    return r;
  endfunction

  // Measured one-way latency of known rate and buffer pairs.
  function automatic base_hit_t base_lookup(logic [SR_W-1:0] sr, logic [FRAMES_W-1:0] fr);
    base_hit_t r;
    r.hit = 1'b1;
    r.us  = '0;
    if (sr == 18'd192000 && fr == 13'd128) r.us = 20'd2450;
    else if (sr == 18'd192000 && fr == 13'd96) r.us = 20'd2250;
    else if (sr == 18'd192000 && fr == 13'd64) r.us = 20'd2100;
    else if (sr == 18'd96000 && fr == 13'd128) r.us = 20'd5200;
    else if (sr == 18'd96000 && fr == 13'd96) r.us = 20'd2850;
    else if (sr == 18'd96000 && fr == 13'd64) r.us = 20'd2500;
    else if (sr == 18'd48000 && fr == 13'd128) r.us = 20'd7250;
    else if (sr == 18'd48000 && fr == 13'd96) r.us = 20'd4600;
    else if (sr == 18'd48000 && fr == 13'd64) r.us = 20'd3900;
    else if (sr == 18'd44100 && fr == 13'd128) r.us = 20'd7550;
    else if (sr == 18'd44100 && fr == 13'd96) r.us = 20'd6850;
    else if (sr == 18'd44100 && fr == 13'd64) r.us = 20'd4100;
    else r.hit = 1'b0;
    return r;
  endfunction

endpackage

@@ rtl/aabs_if.sv @@
// Valid/ready channel interfaces of the block size controller.
// Depends on aabs_pkg for field widths.
interface aabs_in_if;
  logic                            valid;
  logic                            ready;
  logic [aabs_pkg::CB_W-1:0]       callback_time_us;
  logic [aabs_pkg::FRAMES_W-1:0]   host_frames;
  logic                            underrun;
  modport source (output valid, callback_time_us, host_frames, underrun, input ready);
  modport sink (input valid, callback_time_us, host_frames, underrun, output ready);
endinterface

interface aabs_out_if;
  logic                            valid;
  logic                            ready;
  logic [aabs_pkg::SIZE_W-1:0]     block_size;
  logic [aabs_pkg::REASON_W-1:0]   switch_reason;
  modport source (output valid, block_size, switch_reason, input ready);
  modport sink (input valid, block_size, switch_reason, output ready);
endinterface

interface aabs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [aabs_pkg::CFG_IDX_W-1:0]   reg_index;
  logic [aabs_pkg::CFG_DATA_W-1:0]  wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

@@ rtl/aabs_mul.sv @@
// Bit-serial shift-add multiplier, one bit of operand b per cycle, early finish.
// Depends on aabs_pkg for the request and response structs.
module aabs_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  aabs_pkg::mul_req_t req_i,
  output aabs_pkg::mul_rsp_t rsp_o
);

  logic [aabs_pkg::MUL_AW-1:0] a_q, acc_q;
  logic [aabs_pkg::MUL_BW-1:0] b_q;
  logic                        busy_q, done_q;
  logic                        last;

  assign last = (b_q[aabs_pkg::MUL_BW-1:1] == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      busy_q <= !last;
      done_q <= last;
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      a_q   <= req_i.a;
      b_q   <= req_i.b;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign rsp_o.busy    = busy_q;
  assign rsp_o.done    = done_q;
  assign rsp_o.product = acc_q;

endmodule

@@ rtl/aabs_div.sv @@
// Restoring divider, one quotient bit per cycle, quotient saturated to 20 bits.
// Depends on aabs_pkg for the request and response structs.
module aabs_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  aabs_pkg::div_req_t req_i,
  output aabs_pkg::div_rsp_t rsp_o
);

  logic [aabs_pkg::SR_W-1:0]   d_q, rem_q;
  logic [aabs_pkg::DIV_NW-1:0] num_q, quot_q;
  logic [aabs_pkg::DIV_CW-1:0] cnt_q;
  logic                        busy_q, done_q;
  logic [aabs_pkg::SR_W:0]     trial;
  logic                        ge;
  logic                        last;

  assign trial = {rem_q, num_q[aabs_pkg::DIV_NW-1]};
  assign ge    = (trial >= {1'b0, d_q});
  assign last  = (cnt_q == aabs_pkg::DIV_CW'(aabs_pkg::DIV_NW - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      busy_q <= !last;
      done_q <= last;
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      d_q    <= req_i.denom;
      num_q  <= req_i.numer;
      rem_q  <= '0;
      quot_q <= '0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      // A remainder below the divisor always fits back into its 18 bits.
      rem_q  <= ge ? aabs_pkg::SR_W'(trial - {1'b0, d_q}) : trial[aabs_pkg::SR_W-1:0];
      num_q  <= num_q << 1;
      quot_q <= {quot_q[aabs_pkg::DIV_NW-2:0], ge};
      cnt_q  <= cnt_q + 1'b1;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = (quot_q[aabs_pkg::DIV_NW-1:aabs_pkg::US_W] != '0)
                    ? '1 : quot_q[aabs_pkg::US_W-1:0];

endmodule

@@ rtl/adaptive_audio_block_size_controller.sv @@
// Top level of the adaptive audio block size controller: sequencer, history memory
// and state registers. Depends on aabs_pkg, aabs_if, aabs_mul, aabs_div, assert_macros.svh.
//
//   channel | dir | handshake     | payload
//   in_i    | in  | valid/ready   | callback_time_us, host_frames, underrun
//   out_o   | out | valid/ready   | block_size, switch_reason
//   cfg_i   | in  | valid/ready   | reg_index, wdata
//
// One item at a time; how long an item takes is set by the bit-serial multiplier
// (up to eleven products an item) and, when the base latency is recomputed, by
// the restoring divider.
// Reset is asynchronous; the history memory needs no clearing pass.
// A result waits in the output register; the next item is taken once that result
// is registered, and the sequencer only holds when a second result is ready.
`include "assert_macros.svh"

module adaptive_audio_block_size_controller #(
  parameter int unsigned HISTORY_DEPTH = aabs_pkg::HISTORY_DEPTH_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  aabs_in_if.sink    in_i,
  aabs_out_if.source out_o,
  aabs_cfg_if.sink   cfg_i
);

  localparam int unsigned HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SW = aabs_pkg::CB_W + CW;

  aabs_pkg::state_e state_q, state_d;
  aabs_pkg::mul_req_t mul_req;
  aabs_pkg::mul_rsp_t mul_rsp;
  aabs_pkg::div_req_t div_req;
  aabs_pkg::div_rsp_t div_rsp;

  // Configuration registers.
  logic [aabs_pkg::SR_W-1:0]    sr_q;
  logic [aabs_pkg::US_W-1:0]    target_q, max_q, margin_q;
  logic [aabs_pkg::Q8_W-1:0]    upper_q, lower_q, overld_q;
  logic [aabs_pkg::FSS_W-1:0]   cool_q;

  // Controller state.
  logic [CW-1:0]                hist_count_q;
  logic [HW-1:0]                hist_head_q;
  logic [SW-1:0]                sum_q;
  logic [aabs_pkg::IDX_W-1:0]   size_q, em_q;
  logic [aabs_pkg::FSS_W-1:0]   fss_q;
  logic [aabs_pkg::FRAMES_W-1:0] latched_q;
  logic [aabs_pkg::US_W-1:0]    base_q;
  logic                         from_cfg_q;
  logic                         out_valid_q;
  aabs_pkg::reason_e            reason_q;

  // Per-item working registers.
  logic [aabs_pkg::CB_W-1:0]    cb_q, old_q;
  logic                         under_q, miss_q, high_q, low_q;
  logic [aabs_pkg::MUL_AW-1:0]  lhs_q, den_q;
  logic [aabs_pkg::SIZE_W-1:0]  out_size_q;
  logic [aabs_pkg::REASON_W-1:0] out_reason_q;

  logic [aabs_pkg::CB_W-1:0]    hist_mem [HISTORY_DEPTH];

  logic                         in_fire, cfg_fire, new_hf, hist_full;
  logic [aabs_pkg::SR_W-1:0]    cfg_sr;
  logic [36:0]                  cool_prod;
  logic [aabs_pkg::FSS_W-1:0]   cool_new;
  logic [aabs_pkg::FSS_W:0]     fss_sum;
  logic [aabs_pkg::FSS_W-1:0]   fss_add;
  aabs_pkg::base_hit_t          tab;
  logic [HW:0]                  head_inc;
  logic [aabs_pkg::US_W:0]      fixed_dn;
  logic                         fixed_over;
  logic [aabs_pkg::IDX_W:0]     up_c;
  aabs_pkg::state_e             base_ret;

  assign in_i.ready  = (state_q == aabs_pkg::ST_IDLE);
  assign cfg_i.ready = (state_q == aabs_pkg::ST_IDLE) && !in_i.valid;
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  assign new_hf    = (in_i.host_frames != '0) && (in_i.host_frames != latched_q);
  assign hist_full = (hist_count_q == CW'(HISTORY_DEPTH));
  assign cfg_sr    = cfg_i.wdata[aabs_pkg::SR_W-1:0];
  assign cool_prod = 37'(cfg_sr) * 37'(aabs_pkg::COOL_RECIP);
  assign cool_new  = aabs_pkg::FSS_W'(cool_prod >> aabs_pkg::COOL_SHIFT);
  assign fss_sum   = (aabs_pkg::FSS_W + 1)'(fss_q) + (aabs_pkg::FSS_W + 1)'(latched_q);
  assign fss_add   = fss_sum[aabs_pkg::FSS_W] ? '1 : fss_sum[aabs_pkg::FSS_W-1:0];
  assign tab       = aabs_pkg::base_lookup(sr_q, latched_q);
  assign head_inc  = (HW + 1)'(hist_head_q) + 1'b1;
  assign fixed_dn  = (aabs_pkg::US_W + 1)'(base_q) + (aabs_pkg::US_W + 1)'(margin_q);
  assign fixed_over = (fixed_dn > (aabs_pkg::US_W + 1)'(target_q));
  assign up_c      = ((aabs_pkg::IDX_W + 1)'(size_q) + 1'b1 < (aabs_pkg::IDX_W + 1)'(em_q))
                   ? (aabs_pkg::IDX_W + 1)'(size_q) + 1'b1 : (aabs_pkg::IDX_W + 1)'(em_q);
  assign base_ret  = from_cfg_q ? aabs_pkg::ST_IDLE : aabs_pkg::ST_HIST_RD;

  aabs_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  aabs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aabs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and the start requests of the shared arithmetic units.
  always_comb begin
    state_d = state_q;
    mul_req = '0;
    div_req = '0;
    case (state_q)
      aabs_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = new_hf ? aabs_pkg::ST_BASE_SEL : aabs_pkg::ST_HIST_RD;
        end else if (cfg_fire && cfg_i.reg_index == aabs_pkg::REG_SAMPLE_RATE
                     && cfg_sr != '0) begin
          state_d = aabs_pkg::ST_BASE_SEL;
        end
      end
      aabs_pkg::ST_BASE_SEL: begin
        if (latched_q == '0 || tab.hit) begin
          state_d = base_ret;
        end else begin
          mul_req.start = 1'b1;
          mul_req.a     = aabs_pkg::MUL_AW'(latched_q);
          mul_req.b     = aabs_pkg::US_PER_S;
          state_d       = aabs_pkg::ST_BASE_MUL;
        end
      end
      aabs_pkg::ST_BASE_MUL: begin
        if (mul_rsp.done) begin
          div_req.start = 1'b1;
          div_req.numer = mul_rsp.product[aabs_pkg::DIV_NW-1:0];
          div_req.denom = sr_q;
          state_d       = aabs_pkg::ST_BASE_DIV;
        end
      end
      aabs_pkg::ST_BASE_DIV: begin
        if (div_rsp.done) begin
          state_d = base_ret;
        end
      end
      aabs_pkg::ST_HIST_RD: state_d = aabs_pkg::ST_HIST_WR;
      aabs_pkg::ST_HIST_WR: begin
        mul_req.start = 1'b1;
        mul_req.a     = aabs_pkg::MUL_AW'(cb_q);
        mul_req.b     = aabs_pkg::MUL_BW'(sr_q);
        state_d       = aabs_pkg::ST_P1;
      end
      aabs_pkg::ST_P1: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = aabs_pkg::MUL_AW'(overld_q);
          mul_req.b     = aabs_pkg::MUL_BW'(latched_q);
          state_d       = aabs_pkg::ST_P2;
        end
      end
      aabs_pkg::ST_P2: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = mul_rsp.product;
          mul_req.b     = aabs_pkg::US_PER_S;
          state_d       = aabs_pkg::ST_P3;
        end
      end
      aabs_pkg::ST_P3: begin
        if (mul_rsp.done) begin
          if (base_q > max_q) begin
            state_d = aabs_pkg::ST_DECIDE;
          end else begin
            mul_req.start = 1'b1;
            mul_req.a     = aabs_pkg::MUL_AW'(max_q - base_q);
            mul_req.b     = aabs_pkg::MUL_BW'(sr_q);
            state_d       = aabs_pkg::ST_P4;
          end
        end
      end
      aabs_pkg::ST_P4: begin
        if (mul_rsp.done) begin
          state_d = aabs_pkg::ST_DECIDE;
        end
      end
      aabs_pkg::ST_DECIDE: begin
        if (under_q || miss_q || fss_q < cool_q) begin
          state_d = aabs_pkg::ST_FINISH;
        end else if (latched_q == '0) begin
          state_d = aabs_pkg::ST_CHOOSE;
        end else begin
          mul_req.start = 1'b1;
          mul_req.a     = aabs_pkg::MUL_AW'(sum_q);
          mul_req.b     = aabs_pkg::MUL_BW'(sr_q);
          state_d       = aabs_pkg::ST_P5;
        end
      end
      aabs_pkg::ST_P5: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = aabs_pkg::MUL_AW'(latched_q);
          mul_req.b     = aabs_pkg::MUL_BW'(hist_count_q);
          state_d       = aabs_pkg::ST_P6;
        end
      end
      aabs_pkg::ST_P6: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = mul_rsp.product;
          mul_req.b     = aabs_pkg::US_PER_S;
          state_d       = aabs_pkg::ST_P7;
        end
      end
      aabs_pkg::ST_P7: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = mul_rsp.product;
          mul_req.b     = aabs_pkg::MUL_BW'(upper_q);
          state_d       = aabs_pkg::ST_P8;
        end
      end
      aabs_pkg::ST_P8: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = den_q;
          mul_req.b     = aabs_pkg::MUL_BW'(lower_q);
          state_d       = aabs_pkg::ST_P9;
        end
      end
      aabs_pkg::ST_P9: begin
        if (mul_rsp.done) begin
          state_d = aabs_pkg::ST_CHOOSE;
        end
      end
      aabs_pkg::ST_CHOOSE: begin
        if (!high_q && low_q && size_q != '0 && !fixed_over) begin
          mul_req.start = 1'b1;
          mul_req.a     = aabs_pkg::MUL_AW'(target_q - aabs_pkg::US_W'(fixed_dn));
          mul_req.b     = aabs_pkg::MUL_BW'(sr_q);
          state_d       = aabs_pkg::ST_P10;
        end else begin
          state_d = aabs_pkg::ST_FINISH;
        end
      end
      aabs_pkg::ST_P10: begin
        if (mul_rsp.done) begin
          state_d = aabs_pkg::ST_FINISH;
        end
      end
      aabs_pkg::ST_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = aabs_pkg::ST_IDLE;
        end
      end
      default: state_d = aabs_pkg::ST_IDLE;
    endcase
  end

  // History memory: the oldest entry is read in the cycle before it is overwritten.
  always_ff @(posedge clk_i) begin
    if (state_q == aabs_pkg::ST_HIST_RD) begin
      old_q <= hist_mem[hist_head_q];
    end
    if (state_q == aabs_pkg::ST_HIST_WR) begin
      hist_mem[hist_head_q] <= cb_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q         <= aabs_pkg::SR_RESET;
      target_q     <= aabs_pkg::TARGET_RESET;
      max_q        <= aabs_pkg::MAX_RESET;
      margin_q     <= aabs_pkg::MARGIN_RESET;
      upper_q      <= aabs_pkg::UPPER_RESET;
      lower_q      <= aabs_pkg::LOWER_RESET;
      overld_q     <= aabs_pkg::OVERLD_RESET;
      cool_q       <= aabs_pkg::COOL_RESET;
      hist_count_q <= '0;
      hist_head_q  <= '0;
      sum_q        <= '0;
      size_q       <= aabs_pkg::IDX_RESET;
      em_q         <= '0;
      fss_q        <= aabs_pkg::COOL_RESET;
      latched_q    <= '0;
      base_q       <= '0;
      from_cfg_q   <= 1'b0;
      reason_q     <= aabs_pkg::RSN_NONE;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        aabs_pkg::ST_IDLE: begin
          if (in_fire) begin
            if (new_hf) begin
              latched_q  <= in_i.host_frames;
              fss_q      <= cool_q;
              from_cfg_q <= 1'b0;
            end
          end else if (cfg_fire) begin
            case (aabs_pkg::cfg_reg_e'(cfg_i.reg_index))
              aabs_pkg::REG_SAMPLE_RATE: begin
                // A zero rate is ignored; otherwise the base latency is recomputed.
                if (cfg_sr != '0) begin
                  sr_q       <= cfg_sr;
                  cool_q     <= cool_new;
                  fss_q      <= cool_new;
                  from_cfg_q <= 1'b1;
                end
              end
              aabs_pkg::REG_TARGET_LAT:  target_q <= cfg_i.wdata;
              aabs_pkg::REG_MAX_LAT:     max_q    <= cfg_i.wdata;
              aabs_pkg::REG_MARGIN:      margin_q <= cfg_i.wdata;
              aabs_pkg::REG_UPPER_LOAD:  upper_q  <= cfg_i.wdata[aabs_pkg::Q8_W-1:0];
              aabs_pkg::REG_LOWER_LOAD:  lower_q  <= cfg_i.wdata[aabs_pkg::Q8_W-1:0];
              aabs_pkg::REG_FAST_OVERLD: overld_q <= cfg_i.wdata[aabs_pkg::Q8_W-1:0];
              aabs_pkg::REG_START_SIZE:
                size_q <= aabs_pkg::pick_start(cfg_i.wdata[aabs_pkg::START_W-1:0]);
              default: ;
            endcase
          end
        end
        aabs_pkg::ST_BASE_SEL: begin
          if (latched_q == '0) begin
            base_q <= '0;
          end else if (tab.hit) begin
            base_q <= tab.us;
          end
        end
        aabs_pkg::ST_BASE_DIV: begin
          if (div_rsp.done) begin
            base_q <= div_rsp.quot;
          end
        end
        aabs_pkg::ST_HIST_WR: begin
          sum_q <= sum_q - (hist_full ? SW'(old_q) : '0) + SW'(cb_q);
          if (!hist_full) begin
            hist_count_q <= hist_count_q + 1'b1;
          end
          hist_head_q <= (head_inc >= (HW + 1)'(HISTORY_DEPTH)) ? '0 : head_inc[HW-1:0];
        end
        aabs_pkg::ST_P3: begin
          if (mul_rsp.done && base_q > max_q) begin
            em_q <= '0;
          end
        end
        aabs_pkg::ST_P4: begin
          if (mul_rsp.done) begin
            if (mul_rsp.product >= aabs_pkg::size_cost(2'd2)) begin
              em_q <= 2'd2;
            end else if (mul_rsp.product >= aabs_pkg::size_cost(2'd1)) begin
              em_q <= 2'd1;
            end else begin
              em_q <= 2'd0;
            end
          end
        end
        aabs_pkg::ST_DECIDE: begin
          reason_q <= aabs_pkg::RSN_NONE;
          if (under_q || miss_q) begin
            if (em_q > size_q) begin
              size_q   <= em_q;
              fss_q    <= '0;
              reason_q <= aabs_pkg::RSN_FAST_UP;
            end else begin
              reason_q <= aabs_pkg::RSN_CRIT;
            end
          end else if (fss_q < cool_q) begin
            fss_q <= fss_add;
          end
        end
        aabs_pkg::ST_CHOOSE: begin
          if (high_q) begin
            if (up_c > (aabs_pkg::IDX_W + 1)'(size_q)) begin
              size_q   <= up_c[aabs_pkg::IDX_W-1:0];
              fss_q    <= '0;
              reason_q <= aabs_pkg::RSN_STEP_UP;
            end else begin
              fss_q <= fss_add;
            end
          end else if (!(low_q && size_q != '0 && !fixed_over)) begin
            fss_q <= fss_add;
          end
        end
        aabs_pkg::ST_P10: begin
          if (mul_rsp.done) begin
            if (mul_rsp.product >= aabs_pkg::size_cost(size_q - 1'b1)) begin
              size_q   <= size_q - 1'b1;
              fss_q    <= '0;
              reason_q <= aabs_pkg::RSN_STEP_DN;
            end else begin
              fss_q <= fss_add;
            end
          end
        end
        aabs_pkg::ST_FINISH: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Per-item working values; no reset needed.
  always_ff @(posedge clk_i) begin
    case (state_q)
      aabs_pkg::ST_IDLE: begin
        if (in_fire) begin
          cb_q    <= in_i.callback_time_us;
          under_q <= in_i.underrun;
        end
      end
      aabs_pkg::ST_P1: begin
        if (mul_rsp.done) begin
          lhs_q <= mul_rsp.product << 8;
        end
      end
      aabs_pkg::ST_P3: begin
        if (mul_rsp.done) begin
          // No latched buffer length means no period, so no deadline miss.
          miss_q <= (latched_q != '0) && (lhs_q > mul_rsp.product);
        end
      end
      aabs_pkg::ST_DECIDE: begin
        high_q <= 1'b0;
        low_q  <= (lower_q != '0);
      end
      aabs_pkg::ST_P5: begin
        if (mul_rsp.done) begin
          lhs_q <= mul_rsp.product << 8;
        end
      end
      aabs_pkg::ST_P7: begin
        if (mul_rsp.done) begin
          den_q <= mul_rsp.product;
        end
      end
      aabs_pkg::ST_P8: begin
        if (mul_rsp.done) begin
          high_q <= (lhs_q > mul_rsp.product);
        end
      end
      aabs_pkg::ST_P9: begin
        if (mul_rsp.done) begin
          low_q <= (lhs_q < mul_rsp.product);
        end
      end
      aabs_pkg::ST_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          out_size_q   <= aabs_pkg::size_of(size_q);
          out_reason_q <= reason_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.block_size    = out_size_q;
  assign out_o.switch_reason = out_reason_q;

  `AABS_ASSERT(a_in_leaves_idle, in_fire |=> state_q != aabs_pkg::ST_IDLE, "item accepted but sequencer stayed idle")
  `AABS_ASSERT(a_mul_start_free, mul_req.start |-> !mul_rsp.busy, "multiplier started while busy")
  `AABS_ASSERT(a_div_start_free, div_req.start |-> !div_rsp.busy, "divider started while busy")
  `AABS_ASSERT(a_out_from_finish, $rose(out_valid_q) |-> $past(state_q) == aabs_pkg::ST_FINISH, "result raised outside finish")
  `AABS_ASSERT(a_hist_count, state_q == aabs_pkg::ST_HIST_WR |=> hist_count_q != '0, "history count zero after a write")

endmodule

@@ tb/aabs_scoreboard.sv @@
// Checker of the block size controller: watches the config, input and result channels,
// predicts each result and compares it. Depends on aabs_pkg and the aabs_if interfaces.
module aabs_scoreboard (
  input  logic  clk_i,
  input  logic  rst_ni,
  aabs_in_if    in_mon,
  aabs_out_if   out_mon,
  aabs_cfg_if   cfg_mon,
  output int    fail_count_o,
  output int    outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import aabs_pkg::*;

  localparam int unsigned DEPTH = 64;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    reason_e           reason;
  } decision_t;

  decision_t decision_q[$];
  int        fails;

  longint unsigned rate, target_us, max_us, margin_us, upper_q8, lower_q8, overload_q8;
  longint unsigned win_ring [DEPTH];
  longint unsigned win_sum, since_switch, frames_lat, base_us;
  int unsigned     win_count, win_head, size_idx;

  assign fail_count_o  = fails;
  assign outstanding_o = decision_q.size();

  function automatic longint unsigned size_at(int unsigned i);
    return (i == 2) ? 128 : (i == 1) ? 96 : 64;
  endfunction

  function automatic void refresh_base();
    longint unsigned v;
    base_us = 0;
    if (frames_lat == 0) return;
    case ({rate, frames_lat})
      {64'd192000, 64'd128}: base_us = 2450;
      {64'd192000, 64'd96}:  base_us = 2250;
      {64'd192000, 64'd64}:  base_us = 2100;
      {64'd96000, 64'd128}:  base_us = 5200;
      {64'd96000, 64'd96}:   base_us = 2850;
      {64'd96000, 64'd64}:   base_us = 2500;
      {64'd48000, 64'd128}:  base_us = 7250;
      {64'd48000, 64'd96}:   base_us = 4600;
      {64'd48000, 64'd64}:   base_us = 3900;
      {64'd44100, 64'd128}:  base_us = 7550;
      {64'd44100, 64'd96}:   base_us = 6850;
      {64'd44100, 64'd64}:   base_us = 4100;
      default: begin
        v = frames_lat * 1000000 / rate;
        base_us = (v > 64'hFFFFF) ? 64'hFFFFF : v;
      end
    endcase
  endfunction

  // Exact test of base + b/(2*rate) + extra <= limit.
  function automatic logic latency_fits(longint unsigned b, longint unsigned limit,
                                        longint unsigned extra);
    longint unsigned fixed_us;
    fixed_us = base_us + extra;
    if (fixed_us > limit) return 1'b0;
    return b * 500000 <= (limit - fixed_us) * rate;
  endfunction

  function automatic int unsigned largest_fit();
    int unsigned best;
    best = 0;
    for (int unsigned i = 0; i < 3; i++)
      if (latency_fits(size_at(i), max_us, 0)) best = i;
    return best;
  endfunction

  function automatic void count_frames();
    since_switch = (since_switch + frames_lat > 65535) ? 65535 : since_switch + frames_lat;
  endfunction

  function automatic void reset_model();
    rate = 48000; target_us = 10000; max_us = 20000; margin_us = 1000;
    upper_q8 = 205; lower_q8 = 128; overload_q8 = 256;
    win_sum = 0; win_count = 0; win_head = 0; size_idx = 1;
    since_switch = 9600; frames_lat = 0; base_us = 0;
    decision_q.delete();
  endfunction

  function automatic void apply_write(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    longint unsigned p;
    case (idx)
      REG_SAMPLE_RATE: if (data[17:0] != 0) begin
        rate = data[17:0];
        refresh_base();
        since_switch = rate / 5;
      end
      REG_TARGET_LAT:  target_us = data;
      REG_MAX_LAT:     max_us = data;
      REG_MARGIN:      margin_us = data;
      REG_UPPER_LOAD:  upper_q8 = data[15:0];
      REG_LOWER_LOAD:  lower_q8 = data[15:0];
      REG_FAST_OVERLD: overload_q8 = data[15:0];
      REG_START_SIZE: begin
        // Nearest candidate, ties go to the smaller size.
        p = data[12:0];
        if (p == 0) p = 96;
        size_idx = (p <= 80) ? 0 : (p <= 112) ? 1 : 2;
      end
      default: ;
    endcase
  endfunction

  function automatic decision_t predict(logic [CB_W-1:0] cb, logic [FRAMES_W-1:0] hf,
                                        logic under);
    int unsigned em, cur, nxt, rsn, c;
    logic miss, high, low;
    longint unsigned lhs, den;
    decision_t d;
    cur = size_idx; nxt = cur; rsn = RSN_NONE; miss = 1'b0;
    if (hf != 0 && hf != frames_lat) begin
      frames_lat = hf;
      refresh_base();
      since_switch = rate / 5;
    end
    if (win_count >= DEPTH) win_sum -= win_ring[win_head];
    else win_count++;
    win_ring[win_head] = cb;
    win_sum += cb;
    win_head = (win_head + 1) % DEPTH;
    em = largest_fit();
    if (frames_lat != 0)
      miss = longint'(cb) * 256 * rate > overload_q8 * frames_lat * 1000000;
    if (under || miss) begin
      if (em > cur) begin
        size_idx = em; since_switch = 0; rsn = RSN_FAST_UP;
      end else begin
        rsn = RSN_CRIT;
      end
    end else if (since_switch < rate / 5) begin
      count_frames();
    end else begin
      lhs  = win_sum * rate * 256;
      den  = longint'(win_count) * frames_lat * 1000000;
      high = frames_lat != 0 && lhs > upper_q8 * den;
      low  = (frames_lat == 0) ? (lower_q8 > 0) : (lhs < lower_q8 * den);
      if (high) begin
        c = (cur + 1 < em) ? cur + 1 : em;
        if (c > cur) begin
          nxt = c; rsn = RSN_STEP_UP;
        end
      end else if (low) begin
        if (cur > 0 && latency_fits(size_at(cur - 1), target_us, margin_us)) begin
          nxt = cur - 1; rsn = RSN_STEP_DN;
        end
      end
      if (nxt != cur) begin
        size_idx = nxt; since_switch = 0;
      end else begin
        count_frames();
      end
    end
    d.size   = size_at(size_idx);
    d.reason = reason_e'(rsn);
    return d;
  endfunction

  initial fails = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_model();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready)
        apply_write(cfg_reg_e'(cfg_mon.reg_index), cfg_mon.wdata);
      if (in_mon.valid && in_mon.ready)
        decision_q.push_back(predict(in_mon.callback_time_us, in_mon.host_frames,
                                     in_mon.underrun));
      if (out_mon.valid && out_mon.ready) begin
        if (decision_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result transfer: size %0d reason %0d",
                     out_mon.block_size, out_mon.switch_reason);
        end else begin
          if (out_mon.block_size !== decision_q[0].size ||
              out_mon.switch_reason !== decision_q[0].reason) begin
            fails++;
            if (fails <= 10)
              $display("result mismatch: size %0d reason %0d, expected size %0d reason %0d",
                       out_mon.block_size, out_mon.switch_reason,
                       decision_q[0].size, decision_q[0].reason);
          end
          void'(decision_q.pop_front());
        end
      end
    end
  end

endmodule

@@ tb/adaptive_audio_block_size_controller_tb.sv @@
// Top of the block size controller testbench: clock, reset, register phases, callback
// stimulus and result stalls. Depends on aabs_pkg, aabs_if, aabs_scoreboard and the controller top.
module adaptive_audio_block_size_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import aabs_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   outstanding;
  int   cycles;
  int   results_seen;
  logic no_gaps;
  longint unsigned gen_rate, gen_frames;

  aabs_in_if  in_if ();
  aabs_out_if out_if ();
  aabs_cfg_if cfg_if ();

  adaptive_audio_block_size_controller u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  aabs_scoreboard u_scoreboard (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon        (in_if),
    .out_mon       (out_if),
    .cfg_mon       (cfg_if),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == REG_SAMPLE_RATE && data[17:0] != 0) gen_rate = data[17:0];
  endtask

  task automatic write_all(logic [CFG_DATA_W-1:0] v [8]);
    for (int i = 0; i < 8; i++) write_reg(cfg_reg_e'(i), v[i]);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send(logic [CB_W-1:0] cb, logic [FRAMES_W-1:0] hf, logic un);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid            <= 1'b1;
    in_if.callback_time_us <= cb;
    in_if.host_frames      <= hf;
    in_if.underrun         <= un;
    do @(posedge clk_i); while (!in_if.ready);
    if (hf != 0) gen_frames = hf;
  endtask

  // Every item yields a result, so an empty expectation queue means the block is idle.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (outstanding == 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly steady host buffers with a load level that wanders, so the cooldown expires
  // and the step rules get exercised; the rest is buffer changes, misses and noise.
  task automatic random_items(int n);
    longint unsigned period;
    int unsigned lo, hi, sel;
    logic [FRAMES_W-1:0] hf;
    logic [CB_W-1:0] cb;
    lo = 20; hi = 60;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        lo = $urandom_range(0, 110);
        hi = lo + $urandom_range(0, 30);
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      sel = $urandom_range(0, 99);
      if (sel < 85) hf = gen_frames;
      else if (sel < 90) hf = 0;
      else if (sel < 97) hf = 64 + 32 * $urandom_range(0, 2);
      else hf = $urandom;
      if (hf == 0 && gen_frames == 0) hf = 64;
      period = (hf != 0 ? hf : gen_frames) * 1000000 / gen_rate;
      sel = $urandom_range(0, 15);
      if (sel == 0) cb = $urandom;
      else if (sel == 1) cb = period * $urandom_range(100, 300) / 100;
      else cb = period * $urandom_range(lo, hi) / 100;
      send(cb, hf, $urandom_range(0, 31) == 0);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] v [8];
    rst_ni = 1'b0;
    cycles = 0;
    no_gaps = 1'b0;
    gen_rate = 48000;
    gen_frames = 0;
    in_if.valid = 1'b0;
    in_if.callback_time_us = '0;
    in_if.host_frames = '0;
    in_if.underrun = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.reg_index = REG_SAMPLE_RATE;
    cfg_if.wdata = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: no frames latched yet, then the field extremes and both flags.
    send(20'd500, 13'd0, 1'b0);
    send(20'd0, 13'd0, 1'b1);
    send(20'd1000, 13'd64, 1'b0);
    send(20'd1000, 13'd64, 1'b0);
    send(20'd5000, 13'd64, 1'b0);
    send(20'd1000, 13'd64, 1'b1);
    send(20'hFFFFF, 13'd96, 1'b0);
    send(20'd0, 13'd128, 1'b0);
    send(20'd2000, 13'd128, 1'b1);
    send(20'd100, 13'h1FFF, 1'b0);
    send(20'd100, 13'd4096, 1'b0);
    send(20'd100, 13'd1000, 1'b0);
    send(20'h55555, 13'h0AAA, 1'b0);
    send(20'hAAAAA, 13'h1555, 1'b1);
    drain();

    // Low rate keeps the cooldown short; start size write of an exact candidate.
    v = '{20'd8000, 20'd1000000, 20'd1000000, 20'd0, 20'd205, 20'd128, 20'd256, 20'd64};
    write_all(v);
    send(20'd100, 13'd64, 1'b0);
    for (int i = 0; i < 30; i++) send(20'd7000, 13'd0, 1'b0);
    for (int i = 0; i < 70; i++) send(20'd500, 13'd0, 1'b0);
    random_items(300);
    drain();

    // Nothing fits, zero upper and overload thresholds, the largest lower one and start size zero.
    v = '{20'd192000, 20'd0, 20'd0, 20'd1000000, 20'd0, 20'd65535, 20'd0, 20'd0};
    write_all(v);
    random_items(300);
    drain();

    // Extreme thresholds, the largest start size, then a zero sample rate write.
    v = '{20'd44100, 20'd20000, 20'd30000, 20'd500, 20'd65535, 20'd0, 20'd65535, 20'd4096};
    write_all(v);
    write_reg(REG_SAMPLE_RATE, 20'd0);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
    random_items(300);
    drain();

    // Ties in the start size pick the smaller candidate.
    v = '{20'd96000, 20'd6000, 20'd12000, 20'd200, 20'd180, 20'd150, 20'd300, 20'd80};
    write_all(v);
    random_items(150);
    drain();
    write_reg(REG_START_SIZE, 20'd112);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
    random_items(150);
    drain();

    // Largest rate the field holds, with all upper data bits set on every register.
    v = '{20'hFFFFF, 20'hFFFFF, 20'd1000000, 20'd1000, 20'hF00CD, 20'hF0080, 20'hF0100,
          20'hFE060};
    write_all(v);
    gen_rate = 18'h3FFFF;
    random_items(250);
    drain();

    v = '{20'd48000, 20'd10000, 20'd20000, 20'd1000, 20'd205, 20'd128, 20'd256, 20'd96};
    write_all(v);
    random_items(300);

    in_if.valid <= 1'b0;
    wait (outstanding == 0);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold-off that backs the block up.
  initial begin
    int stall;
    results_seen = 0;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 11);
      if (results_seen == 400) stall = 600;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      results_seen++;
    end
  end

endmodule
